>>> rtl/timer_deadline_heap_core_assert.svh
// ----------------------------------------------------------------------------
// Timer deadline heap assertion macros
// Concurrent checks that are compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef TIMER_DEADLINE_HEAP_CORE_ASSERT_SVH
`define TIMER_DEADLINE_HEAP_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define TDH_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

`define TDH_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`else

`define TDH_ASSERT(lbl, ck, rn, prop, msg)

`define TDH_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)

`endif

`endif

>>> rtl/tdh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer deadline heap package
// Shared widths, operation codes and result codes.
// ----------------------------------------------------------------------------
package tdh_pkg;

    localparam int DEPTH_DEF = 128;
    localparam int TIME_W    = 48;
    localparam int MS_W      = 24;
    localparam int PROD_W    = MS_W + 10;
    localparam int TAG_W     = 32;
    localparam int ID_OUT_W  = 7;
    localparam int MODE_W    = 2;
    localparam int STAT_W    = 3;
    localparam int LIVE_W    = 8;
    localparam int CELL_W    = 8;
    localparam int CELL_B    = $clog2(CELL_W);
    localparam int US_PER_MS = 1000;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic [MODE_W-1:0] MODE_ADD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POLL = 2'd2;

    localparam logic [STAT_W-1:0] ST_ADDED   = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STAT_W-1:0] ST_DELETED = 3'd2;
    localparam logic [STAT_W-1:0] ST_IGNORED = 3'd3;
    localparam logic [STAT_W-1:0] ST_POPPED  = 3'd4;
    localparam logic [STAT_W-1:0] ST_NONE    = 3'd5;

endpackage

>>> rtl/tdh_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer deadline heap occupancy cell
// Holds the in-use flags of one group of entries and passes the lowest free
// entry seen so far to the next cell every cycle.
// ----------------------------------------------------------------------------
module tdh_cell #(
    parameter int DEPTH    = tdh_pkg::DEPTH_DEF,
    parameter int IW       = 7,
    parameter int CELL_IDX = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          upd_en,
    input  logic          upd_set,
    input  logic [IW-1:0] upd_id,
    input  logic [IW-1:0] q_id,
    input  logic          prev_found,
    input  logic [IW-1:0] prev_id,
    output logic          found,
    output logic [IW-1:0] free_id,
    output logic          q_hit
);
    import tdh_pkg::*;

    localparam int BASE = CELL_IDX * CELL_W;

    logic [CELL_W-1:0] used_reg;
    logic [CELL_W-1:0] used_next;
    logic [CELL_W-1:0] avail;
    logic [CELL_B-1:0] loc;
    logic [IW+CELL_B-1:0] upd_ext;
    logic [IW+CELL_B-1:0] q_ext;
    logic          found_reg;
    logic          found_next;
    logic [IW-1:0] id_reg;
    logic [IW-1:0] id_next;

    assign upd_ext = (IW+CELL_B)'(upd_id);
    assign q_ext   = (IW+CELL_B)'(q_id);

    always_comb
    begin
        used_next = used_reg;
        if (upd_en && upd_ext[IW+CELL_B-1:CELL_B] == IW'(CELL_IDX))
        begin
            used_next[upd_ext[CELL_B-1:0]] = upd_set;
        end
        for (int b = 0; b < CELL_W; b++)
        begin
            avail[b] = !used_reg[b] && (BASE + b < DEPTH);
        end
        loc = '0;
        for (int b = CELL_W - 1; b >= 0; b--)
        begin
            if (avail[b])
            begin
                loc = CELL_B'(b);
            end
        end
        found_next = prev_found || (|avail);
        id_next    = prev_found ? prev_id : IW'(BASE + int'(loc));
    end

    assign q_hit   = (q_ext[IW+CELL_B-1:CELL_B] == IW'(CELL_IDX)) && used_reg[q_ext[CELL_B-1:0]];
    assign found   = found_reg;
    assign free_id = id_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            used_reg  <= used_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

endmodule

>>> rtl/timer_deadline_heap_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer deadline heap core
// Timer queue ordered by deadline in a binary min-heap, with a chain of
// occupancy cells that finds the lowest free entry.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake         Payload
// in       sink       in_valid/stall   mode, now_us, interval_ms, user_tag, target_id
// out      source     out_valid/stall  status, entry_id, tag_out, live_count
//
// One transaction at a time. Add waits for the cell chain to settle, then
// sifts the new entry up. Delete and poll read the target or root entry
// and refill its slot with the last entry, which then sifts up or down;
// sift up reads the parent per level, sift down both children.
// Reset clears the cells, the live count and the output valid flag; no sweep.
// A stalled result holds the core in its final state until taken.
// ----------------------------------------------------------------------------
`include "timer_deadline_heap_core_assert.svh"

module timer_deadline_heap_core #(
    parameter int DEPTH = tdh_pkg::DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [tdh_pkg::MODE_W-1:0]      mode,
    input  logic [tdh_pkg::TIME_W-1:0]      now_us,
    input  logic [tdh_pkg::MS_W-1:0]        interval_ms,
    input  logic [tdh_pkg::TAG_W-1:0]       user_tag,
    input  logic [tdh_pkg::ID_OUT_W-1:0]    target_id,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [tdh_pkg::STAT_W-1:0]      status,
    output logic [tdh_pkg::ID_OUT_W-1:0]    entry_id,
    output logic [tdh_pkg::TAG_W-1:0]       tag_out,
    output logic [tdh_pkg::LIVE_W-1:0]      live_count
);
    import tdh_pkg::*;

    localparam int IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int NC  = (DEPTH + CELL_W - 1) / CELL_W;
    localparam int WW  = $clog2(NC + 1);
    localparam int CHW = IW + 2;

    typedef enum logic [4:0] {
        S_IDLE, S_FIND, S_DEL_A, S_DEL_B, S_MV_A, S_MV_B, S_MV_C, S_MV_D,
        S_POLL_A, S_POLL_B, S_POLL_C, S_SU_A, S_SU_B, S_SU_C,
        S_SD_A, S_SD_B, S_SD_C, S_SD_D, S_FIN
    } state_t;

    state_t state_reg, state_next;

    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [MS_W-1:0]     ivl_reg, ivl_next;
    logic [TAG_W-1:0]    utag_reg, utag_next;
    logic [ID_OUT_W-1:0] tgt_reg, tgt_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [WW-1:0]       wait_reg, wait_next;
    logic [IW-1:0]       mv_reg, mv_next;
    logic [TIME_W-1:0]   dlm_reg, dlm_next;
    logic [IW-1:0]       slot_reg, slot_next;
    logic [IW-1:0]       par_reg, par_next;
    logic [IW-1:0]       pid_reg, pid_next;
    logic [IW-1:0]       c0_reg, c0_next;
    logic [TIME_W-1:0]   d0_reg, d0_next;
    logic [STAT_W-1:0]   st_reg, st_next;
    logic [IW-1:0]       eid_reg, eid_next;
    logic [TAG_W-1:0]    tout_reg, tout_next;

    logic                out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]   status_reg, status_next;
    logic [ID_OUT_W-1:0] entry_id_reg, entry_id_next;
    logic [TAG_W-1:0]    tag_out_reg, tag_out_next;
    logic [LIVE_W-1:0]   live_reg, live_next;

    logic [TIME_W-1:0] dl_mem  [DEPTH];
    logic [TAG_W-1:0]  tag_mem [DEPTH];
    logic [IW-1:0]     ord_mem [DEPTH];
    logic [IW-1:0]     pos_mem [DEPTH];

    logic              dl_we, tag_we, ord_we, pos_we;
    logic [IW-1:0]     dl_wa, tag_wa, ord_wa, pos_wa;
    logic [IW-1:0]     dl_ra, tag_ra, ord_ra, pos_ra;
    logic [TIME_W-1:0] dl_wd, dl_rd;
    logic [TAG_W-1:0]  tag_wd, tag_rd;
    logic [IW-1:0]     ord_wd, ord_rd, pos_wd, pos_rd;

    logic          upd_en, upd_set;
    logic [IW-1:0] upd_id;
    logic [IW-1:0] tgt_id;
    logic [NC-1:0] tok_found;
    logic [IW-1:0] tok_id [NC];
    logic [NC-1:0] q_hits;

    logic [PROD_W-1:0] prod;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] dl_new;
    logic [CHW-1:0]    ch, ch1, cnt_ext;
    logic [CW-1:0]     cnt_dec;
    logic              tgt_ok;
    logic [IW-1:0]     best_id;
    logic [TIME_W-1:0] best_dl;
    logic [IW-1:0]     best_slot;

    assign tgt_id  = IW'(tgt_reg);
    assign tgt_ok  = (32'(tgt_reg) < 32'(DEPTH)) && (|q_hits);
    assign prod    = PROD_W'(ivl_reg) * PROD_W'(US_PER_MS);
    assign sum     = (TIME_W+1)'(now_reg) + (TIME_W+1)'(prod);
    assign dl_new  = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    assign ch      = CHW'({slot_reg, 1'b1});
    assign ch1     = ch + CHW'(1);
    assign cnt_ext = CHW'(cnt_reg);
    assign cnt_dec = cnt_reg - CW'(1);

    genvar g;
    generate
        for (g = 0; g < NC; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                tdh_cell #(.DEPTH(DEPTH), .IW(IW), .CELL_IDX(g)) u_cell (
                    .clk(clk), .rst_n(rst_n),
                    .upd_en(upd_en), .upd_set(upd_set), .upd_id(upd_id),
                    .q_id(tgt_id),
                    .prev_found(1'b0), .prev_id('0),
                    .found(tok_found[g]), .free_id(tok_id[g]), .q_hit(q_hits[g])
                );
            end
            else
            begin : g_link
                tdh_cell #(.DEPTH(DEPTH), .IW(IW), .CELL_IDX(g)) u_cell (
                    .clk(clk), .rst_n(rst_n),
                    .upd_en(upd_en), .upd_set(upd_set), .upd_id(upd_id),
                    .q_id(tgt_id),
                    .prev_found(tok_found[g-1]), .prev_id(tok_id[g-1]),
                    .found(tok_found[g]), .free_id(tok_id[g]), .q_hit(q_hits[g])
                );
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (dl_we)
        begin
            dl_mem[dl_wa] <= dl_wd;
        end
        dl_rd <= dl_mem[dl_ra];
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_wa] <= tag_wd;
        end
        tag_rd <= tag_mem[tag_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
        begin
            ord_mem[ord_wa] <= ord_wd;
        end
        ord_rd <= ord_mem[ord_ra];
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[pos_wa] <= pos_wd;
        end
        pos_rd <= pos_mem[pos_ra];
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        now_next   = now_reg;
        ivl_next   = ivl_reg;
        utag_next  = utag_reg;
        tgt_next   = tgt_reg;
        cnt_next   = cnt_reg;
        wait_next  = wait_reg;
        mv_next    = mv_reg;
        dlm_next   = dlm_reg;
        slot_next  = slot_reg;
        par_next   = par_reg;
        pid_next   = pid_reg;
        c0_next    = c0_reg;
        d0_next    = d0_reg;
        st_next    = st_reg;
        eid_next   = eid_reg;
        tout_next  = tout_reg;

        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        entry_id_next  = entry_id_reg;
        tag_out_next   = tag_out_reg;
        live_next      = live_reg;

        dl_we  = 1'b0;  dl_wa  = '0; dl_wd  = dl_new; dl_ra  = '0;
        tag_we = 1'b0;  tag_wa = '0; tag_wd = utag_reg; tag_ra = '0;
        ord_we = 1'b0;  ord_wa = '0; ord_wd = '0; ord_ra = '0;
        pos_we = 1'b0;  pos_wa = '0; pos_wd = '0; pos_ra = '0;
        upd_en = 1'b0;  upd_set = 1'b0; upd_id = '0;

        best_id   = c0_reg;
        best_dl   = d0_reg;
        best_slot = ch[IW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next = mode;
                    now_next  = now_us;
                    ivl_next  = interval_ms;
                    utag_next = user_tag;
                    tgt_next  = target_id;
                    st_next   = ST_NONE;
                    eid_next  = '0;
                    tout_next = '0;
                    wait_next = '0;
                    if (mode == MODE_ADD)
                    begin
                        state_next = S_FIND;
                    end
                    else if (mode == MODE_DEL)
                    begin
                        state_next = S_DEL_A;
                    end
                    else if (mode == MODE_POLL && cnt_reg != '0)
                    begin
                        state_next = S_POLL_A;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIND:
            begin
                wait_next = wait_reg + WW'(1);
                if (wait_reg == WW'(NC))
                begin
                    if (!tok_found[NC-1])
                    begin
                        st_next    = ST_FULL;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        dl_we      = 1'b1;
                        dl_wa      = tok_id[NC-1];
                        tag_we     = 1'b1;
                        tag_wa     = tok_id[NC-1];
                        upd_en     = 1'b1;
                        upd_set    = 1'b1;
                        upd_id     = tok_id[NC-1];
                        mv_next    = tok_id[NC-1];
                        dlm_next   = dl_new;
                        slot_next  = IW'(cnt_reg);
                        cnt_next   = cnt_reg + CW'(1);
                        st_next    = ST_ADDED;
                        eid_next   = tok_id[NC-1];
                        state_next = S_SU_A;
                    end
                end
            end
            S_DEL_A:
            begin
                pos_ra     = tgt_id;
                state_next = S_DEL_B;
            end
            S_DEL_B:
            begin
                if (!tgt_ok)
                begin
                    st_next    = ST_IGNORED;
                    state_next = S_FIN;
                end
                else
                begin
                    st_next   = ST_DELETED;
                    upd_en    = 1'b1;
                    upd_id    = tgt_id;
                    cnt_next  = cnt_dec;
                    slot_next = pos_rd;
                    ord_ra    = IW'(cnt_dec);
                    if (CW'(pos_rd) < cnt_dec)
                    begin
                        state_next = S_MV_A;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_MV_A:
            begin
                mv_next    = ord_rd;
                dl_ra      = ord_rd;
                state_next = S_MV_B;
            end
            S_MV_B:
            begin
                dlm_next = dl_rd;
                par_next = (slot_reg - IW'(1)) >> 1;
                ord_ra   = (slot_reg - IW'(1)) >> 1;
                if (slot_reg == '0)
                begin
                    state_next = S_SD_A;
                end
                else
                begin
                    state_next = S_MV_C;
                end
            end
            S_MV_C:
            begin
                dl_ra      = ord_rd;
                state_next = S_MV_D;
            end
            S_MV_D:
            begin
                if (dlm_reg >= dl_rd)
                begin
                    state_next = S_SD_A;
                end
                else
                begin
                    state_next = S_SU_A;
                end
            end
            S_POLL_A:
            begin
                ord_ra     = '0;
                state_next = S_POLL_B;
            end
            S_POLL_B:
            begin
                dl_ra      = ord_rd;
                tag_ra     = ord_rd;
                pid_next   = ord_rd;
                state_next = S_POLL_C;
            end
            S_POLL_C:
            begin
                if (dl_rd <= now_reg)
                begin
                    st_next   = ST_POPPED;
                    eid_next  = pid_reg;
                    tout_next = tag_rd;
                    upd_en    = 1'b1;
                    upd_id    = pid_reg;
                    cnt_next  = cnt_dec;
                    slot_next = '0;
                    ord_ra    = IW'(cnt_dec);
                    if (cnt_dec != '0)
                    begin
                        state_next = S_MV_A;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_SU_A:
            begin
                par_next = (slot_reg - IW'(1)) >> 1;
                ord_ra   = (slot_reg - IW'(1)) >> 1;
                if (slot_reg == '0)
                begin
                    ord_we     = 1'b1;
                    ord_wa     = slot_reg;
                    ord_wd     = mv_reg;
                    pos_we     = 1'b1;
                    pos_wa     = mv_reg;
                    pos_wd     = slot_reg;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_SU_B;
                end
            end
            S_SU_B:
            begin
                pid_next   = ord_rd;
                dl_ra      = ord_rd;
                state_next = S_SU_C;
            end
            S_SU_C:
            begin
                ord_we = 1'b1;
                ord_wa = slot_reg;
                pos_we = 1'b1;
                pos_wd = slot_reg;
                if (dlm_reg < dl_rd)
                begin
                    ord_wd     = pid_reg;
                    pos_wa     = pid_reg;
                    slot_next  = par_reg;
                    state_next = S_SU_A;
                end
                else
                begin
                    ord_wd     = mv_reg;
                    pos_wa     = mv_reg;
                    state_next = S_FIN;
                end
            end
            S_SD_A:
            begin
                ord_ra = ch[IW-1:0];
                if (ch >= cnt_ext)
                begin
                    ord_we     = 1'b1;
                    ord_wa     = slot_reg;
                    ord_wd     = mv_reg;
                    pos_we     = 1'b1;
                    pos_wa     = mv_reg;
                    pos_wd     = slot_reg;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_SD_B;
                end
            end
            S_SD_B:
            begin
                c0_next    = ord_rd;
                dl_ra      = ord_rd;
                ord_ra     = ch1[IW-1:0];
                state_next = S_SD_C;
            end
            S_SD_C:
            begin
                d0_next = dl_rd;
                if (ch1 < cnt_ext)
                begin
                    pid_next   = ord_rd;
                    dl_ra      = ord_rd;
                    state_next = S_SD_D;
                end
                else
                begin
                    ord_we = 1'b1;
                    ord_wa = slot_reg;
                    pos_we = 1'b1;
                    pos_wd = slot_reg;
                    if (dl_rd < dlm_reg)
                    begin
                        ord_wd     = c0_reg;
                        pos_wa     = c0_reg;
                        slot_next  = ch[IW-1:0];
                        state_next = S_SD_A;
                    end
                    else
                    begin
                        ord_wd     = mv_reg;
                        pos_wa     = mv_reg;
                        state_next = S_FIN;
                    end
                end
            end
            S_SD_D:
            begin
                if (dl_rd < d0_reg)
                begin
                    best_id   = pid_reg;
                    best_dl   = dl_rd;
                    best_slot = ch1[IW-1:0];
                end
                ord_we = 1'b1;
                ord_wa = slot_reg;
                pos_we = 1'b1;
                pos_wd = slot_reg;
                if (best_dl < dlm_reg)
                begin
                    ord_wd     = best_id;
                    pos_wa     = best_id;
                    slot_next  = best_slot;
                    state_next = S_SD_A;
                end
                else
                begin
                    ord_wd     = mv_reg;
                    pos_wa     = mv_reg;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = st_reg;
                    entry_id_next  = ID_OUT_W'(eid_reg);
                    tag_out_next   = tout_reg;
                    live_next      = LIVE_W'(cnt_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            wait_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            wait_reg      <= wait_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        now_reg      <= now_next;
        ivl_reg      <= ivl_next;
        utag_reg     <= utag_next;
        tgt_reg      <= tgt_next;
        mv_reg       <= mv_next;
        dlm_reg      <= dlm_next;
        slot_reg     <= slot_next;
        par_reg      <= par_next;
        pid_reg      <= pid_next;
        c0_reg       <= c0_next;
        d0_reg       <= d0_next;
        st_reg       <= st_next;
        eid_reg      <= eid_next;
        tout_reg     <= tout_next;
        status_reg   <= status_next;
        entry_id_reg <= entry_id_next;
        tag_out_reg  <= tag_out_next;
        live_reg     <= live_next;
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign entry_id   = entry_id_reg;
    assign tag_out    = tag_out_reg;
    assign live_count = live_reg;

    `TDH_ASSERT(a_cnt_bound, clk, rst_n, (32'(cnt_reg) <= 32'(DEPTH)), "live count above depth")
    `TDH_ASSERT_NEXT(a_fin_hold, clk, rst_n, (state_reg == S_FIN && out_valid_reg && out_stall), (state_reg == S_FIN), "result dropped while output stalled")
    `TDH_ASSERT(a_add_live, clk, rst_n, ((out_valid_reg && status_reg == ST_ADDED) |-> (live_reg != '0)), "add reported with no live timer")
    `TDH_ASSERT_NEXT(a_mode_hold, clk, rst_n, (state_reg != S_IDLE), ($stable(mode_reg)), "operation changed mid transaction")

endmodule
